@@ rtl/ipt_pkg.sv @@
// ----------------------------------------------------------------------------
// ipt_pkg: shared types and codes for the ipv4 prefix trie
// Operation and status codes, the queued request record and the sequencer
// state type.
// ----------------------------------------------------------------------------
package ipt_pkg;

  localparam int FIELD_W = 32;

  // operation codes on the input channel
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // status codes on the result channel
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BUSY = 2'd1;
  localparam logic [1:0] STAT_ERR  = 2'd2;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_DELETE,
    KIND_FIND,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [FIELD_W-1:0]  key;
    logic [FIELD_W-1:0]  mask;
    logic [FIELD_W-1:0]  value;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_GRAB,
    ST_FREE,
    ST_MAKE,
    ST_LINK,
    ST_UP,
    ST_UNLINK,
    ST_DONE
  } st_t;

endpackage

@@ rtl/ipt_front.sv @@
// ----------------------------------------------------------------------------
// ipt_front: request intake
// Decodes the operation of each request and holds it in a two-entry queue
// until the trie sequencer takes it.
// ----------------------------------------------------------------------------
module ipt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_operation,
  input  logic [31:0]          in_key,
  input  logic [31:0]          in_prefix_mask,
  input  logic [31:0]          in_insert_value,
  output logic                 q_valid,
  output ipt_pkg::item_t       q_item,
  input  logic                 q_pop
);
  import ipt_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  item_t       incoming;

  // classify the operation code
  always_comb begin
    incoming.key   = in_key;
    incoming.mask  = in_prefix_mask;
    incoming.value = in_insert_value;
    unique case (in_operation)
      OP_INSERT: incoming.kind = KIND_INSERT;
      OP_DELETE: incoming.kind = KIND_DELETE;
      OP_FIND:   incoming.kind = KIND_FIND;
      default:   incoming.kind = KIND_BAD;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

@@ rtl/ipt_back.sv @@
// ----------------------------------------------------------------------------
// ipt_back: trie sequencer
// Walks the node memory one level per cycle for find and the search part of
// insert and delete, allocates and links nodes, frees leaves upward, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module ipt_back #(
  parameter int NODE_COUNT = 4096,
  parameter int KEY_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ipt_pkg::item_t       q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_found,
  output logic [31:0]          out_match_value
);
  import ipt_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int HW = IW + 1;
  localparam int DW = $clog2(KEY_BITS + 1);
  localparam logic [HW-1:0] EMPTY = HW'(NODE_COUNT);

  // bit d of a key-sized vector, counted from the top; zero past the end
  function automatic logic bit_at(input logic [31:0] v, input logic [DW:0] d);
    logic [5:0] p;
    p = 6'(KEY_BITS - 1) - 6'(d);
    if (d >= (DW+1)'(KEY_BITS)) begin
      return 1'b0;
    end
    return v[p[4:0]];
  endfunction

  st_t         state_r, state_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] val_r, val_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        found_r, found_nxt;
  logic [31:0] mval_r, mval_nxt;
  logic [HW-1:0] free_head_r, free_head_nxt;
  logic [HW-1:0] next_unused_r, next_unused_nxt;
  logic [IW-1:0] root_left_r, root_left_nxt;
  logic [IW-1:0] root_right_r, root_right_nxt;
  logic        root_has_r, root_has_nxt;
  logic [31:0] root_val_r, root_val_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_found_r, out_found_nxt;
  logic [31:0] out_mval_r, out_mval_nxt;

  // node memory
  logic [IW-1:0] left_mem   [NODE_COUNT];
  logic [IW-1:0] right_mem  [NODE_COUNT];
  logic [IW-1:0] parent_mem [NODE_COUNT];
  logic [31:0]   val_mem    [NODE_COUNT];
  logic          has_mem    [NODE_COUNT];
  logic [IW-1:0] left_q, right_q, parent_q;
  logic [31:0]   val_q;
  logic          has_q;
  logic [IW-1:0] rd_addr;
  logic          left_we, right_we, parent_we, val_we, has_we;
  logic [IW-1:0] left_wa, right_wa, parent_wa, val_wa, has_wa;
  logic [IW-1:0] left_wd, right_wd, parent_wd;
  logic [31:0]   val_wd;
  logic          has_wd;

  // view of the current node
  logic          at_root;
  logic [IW-1:0] v_left, v_right, v_parent, child;
  logic          v_has;
  logic [31:0]   v_val;
  logic          here, kb, last, leaf, free_avail, unused_avail;
  logic          walk_end, found_now, in_has, right_hit, stop_up, slot_ok;
  logic [31:0]   store_val;

  assign at_root      = (cur_r == '0);
  assign v_left       = at_root ? root_left_r : left_q;
  assign v_right      = at_root ? root_right_r : right_q;
  assign v_has        = at_root ? root_has_r : has_q;
  assign v_val        = at_root ? root_val_r : val_q;
  assign v_parent     = parent_q;
  assign here         = bit_at(mask_r, {1'b0, depth_r});
  assign kb           = bit_at(key_r, {1'b0, depth_r});
  assign last         = !bit_at(mask_r, {1'b0, depth_r} + (DW+1)'(1));
  assign child        = kb ? v_right : v_left;
  assign leaf         = (v_left == '0) && (v_right == '0);
  assign free_avail   = (free_head_r != EMPTY);
  assign unused_avail = (next_unused_r < EMPTY);
  assign walk_end     = (depth_r >= DW'(KEY_BITS)) || (child == '0);
  assign found_now    = found_r || v_has;
  assign in_has       = (val_r != '1);
  assign store_val    = in_has ? val_r : '0;
  assign right_hit    = (v_right == n_r);
  assign stop_up      = (right_hit ? (v_left != '0) : (v_right != '0)) || v_has || at_root;
  assign slot_ok      = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.kind == KIND_BAD) ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        unique case (kind_r)
          KIND_FIND:   state_nxt = walk_end ? ST_DONE : ST_LOOK;
          KIND_INSERT: begin
            priority if (!here)        state_nxt = ST_DONE;
            else if (child == '0)      state_nxt = ST_GRAB;
            else                       state_nxt = ST_LOOK;
          end
          KIND_DELETE: begin
            priority if (here)         state_nxt = (child == '0) ? ST_DONE : ST_LOOK;
            else if (!leaf || at_root) state_nxt = ST_DONE;
            else                       state_nxt = ST_UP;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_GRAB: begin
        priority if (free_avail)  state_nxt = ST_FREE;
        else if (unused_avail)    state_nxt = ST_MAKE;
        else                      state_nxt = ST_DONE;
      end
      ST_FREE:   state_nxt = ST_MAKE;
      ST_MAKE:   state_nxt = ST_LINK;
      ST_LINK:   state_nxt = last ? ST_DONE : ST_GRAB;
      ST_UP:     state_nxt = ST_UNLINK;
      ST_UNLINK: state_nxt = stop_up ? ST_DONE : ST_UP;
      ST_DONE:   state_nxt = slot_ok ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    q_pop           = 1'b0;
    kind_nxt        = kind_r;
    key_nxt         = key_r;
    mask_nxt        = mask_r;
    val_nxt         = val_r;
    cur_nxt         = cur_r;
    depth_nxt       = depth_r;
    n_nxt           = n_r;
    status_nxt      = status_r;
    found_nxt       = found_r;
    mval_nxt        = mval_r;
    free_head_nxt   = free_head_r;
    next_unused_nxt = next_unused_r;
    root_left_nxt   = root_left_r;
    root_right_nxt  = root_right_r;
    root_has_nxt    = root_has_r;
    root_val_nxt    = root_val_r;
    out_valid_nxt   = out_stall ? out_valid_r : 1'b0;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_mval_nxt    = out_mval_r;
    left_we = 1'b0;   left_wa = cur_r;   left_wd = '0;
    right_we = 1'b0;  right_wa = cur_r;  right_wd = '0;
    parent_we = 1'b0; parent_wa = n_r;   parent_wd = cur_r;
    val_we = 1'b0;    val_wa = cur_r;    val_wd = '0;
    has_we = 1'b0;    has_wa = cur_r;    has_wd = 1'b0;
    rd_addr = cur_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          kind_nxt   = q_item.kind;
          key_nxt    = q_item.key;
          mask_nxt   = q_item.mask;
          val_nxt    = q_item.value;
          cur_nxt    = '0;
          depth_nxt  = '0;
          status_nxt = STAT_ERR;
          found_nxt  = 1'b0;
          mval_nxt   = '0;
        end
      end
      ST_LOOK: begin
        unique case (kind_r)
          KIND_FIND: begin
            if (v_has) begin
              found_nxt = 1'b1;
              mval_nxt  = v_val;
            end
            if (walk_end) begin
              status_nxt = found_now ? STAT_OK : STAT_ERR;
            end else begin
              cur_nxt   = child;
              depth_nxt = depth_r + DW'(1);
            end
          end
          KIND_INSERT: begin
            priority if (!here) begin
              // prefix node reached: set its value unless taken
              if (v_has) begin
                status_nxt = STAT_BUSY;
              end else begin
                status_nxt = STAT_OK;
                if (at_root) begin
                  root_has_nxt = in_has;
                  root_val_nxt = store_val;
                end else begin
                  has_we = 1'b1; has_wd = in_has;
                  val_we = 1'b1; val_wd = store_val;
                end
              end
            end else if (child != '0) begin
              cur_nxt   = child;
              depth_nxt = depth_r + DW'(1);
            end
          end
          KIND_DELETE: begin
            priority if (here) begin
              if (child != '0) begin
                cur_nxt   = child;
                depth_nxt = depth_r + DW'(1);
              end
            end else if (!leaf) begin
              // inner node: only its value can go
              if (v_has) begin
                status_nxt = STAT_OK;
                if (at_root) begin
                  root_has_nxt = 1'b0;
                  root_val_nxt = '0;
                end else begin
                  has_we = 1'b1; has_wd = 1'b0;
                  val_we = 1'b1; val_wd = '0;
                end
              end
            end else if (at_root) begin
              status_nxt   = STAT_OK;
              root_has_nxt = 1'b0;
              root_val_nxt = '0;
            end else begin
              status_nxt = STAT_OK;
            end
          end
          default: begin
          end
        endcase
      end
      ST_GRAB: begin
        priority if (free_avail) begin
          n_nxt   = free_head_r[IW-1:0];
          rd_addr = free_head_r[IW-1:0];
        end else if (unused_avail) begin
          n_nxt           = next_unused_r[IW-1:0];
          next_unused_nxt = next_unused_r + HW'(1);
        end else begin
          status_nxt = STAT_ERR;
        end
      end
      ST_FREE: begin
        free_head_nxt = (right_q == '0) ? EMPTY : {1'b0, right_q};
      end
      ST_MAKE: begin
        // fresh node, valued only on the last level
        left_we = 1'b1;   left_wa = n_r;   left_wd = '0;
        right_we = 1'b1;  right_wa = n_r;  right_wd = '0;
        parent_we = 1'b1;
        has_we = 1'b1;    has_wa = n_r;    has_wd = last ? in_has : 1'b0;
        val_we = 1'b1;    val_wa = n_r;    val_wd = last ? store_val : '0;
      end
      ST_LINK: begin
        if (at_root) begin
          if (kb) root_right_nxt = n_r;
          else    root_left_nxt  = n_r;
        end else if (kb) begin
          right_we = 1'b1; right_wd = n_r;
        end else begin
          left_we = 1'b1;  left_wd = n_r;
        end
        cur_nxt   = n_r;
        depth_nxt = depth_r + DW'(1);
        if (last) begin
          status_nxt = STAT_OK;
        end
      end
      ST_UP: begin
        // push the node on the free list and step to its parent
        n_nxt         = cur_r;
        right_we      = 1'b1;
        right_wd      = free_avail ? free_head_r[IW-1:0] : '0;
        free_head_nxt = {1'b0, cur_r};
        cur_nxt       = v_parent;
      end
      ST_UNLINK: begin
        if (at_root) begin
          if (right_hit) root_right_nxt = '0;
          else           root_left_nxt  = '0;
        end else if (right_hit) begin
          right_we = 1'b1; right_wd = '0;
        end else begin
          left_we = 1'b1;  left_wd = '0;
        end
      end
      ST_DONE: begin
        if (slot_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_mval_nxt   = mval_r;
        end
      end
      default: begin
      end
    endcase
    if (state_r != ST_GRAB) begin
      rd_addr = cur_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      free_head_r   <= EMPTY;
      next_unused_r <= HW'(1);
      root_left_r   <= '0;
      root_right_r  <= '0;
      root_has_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      free_head_r   <= free_head_nxt;
      next_unused_r <= next_unused_nxt;
      root_left_r   <= root_left_nxt;
      root_right_r  <= root_right_nxt;
      root_has_r    <= root_has_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    mask_r       <= mask_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    depth_r      <= depth_nxt;
    n_r          <= n_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    mval_r       <= mval_nxt;
    root_val_r   <= root_val_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_mval_r   <= out_mval_nxt;
  end

  // node memory ports
  always_ff @(posedge clk) begin
    if (left_we) left_mem[left_wa] <= left_wd;
    left_q <= left_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (right_we) right_mem[right_wa] <= right_wd;
    right_q <= right_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (parent_we) parent_mem[parent_wa] <= parent_wd;
    parent_q <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (has_we) has_mem[has_wa] <= has_wd;
    has_q <= has_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_match_value = out_mval_r;

endmodule

@@ rtl/ipv4_prefix_trie.sv @@
// ----------------------------------------------------------------------------
// ipv4_prefix_trie: binary trie longest prefix match
// Find and the search part of insert or delete walk one trie level per cycle (up
// to KEY_BITS+1 levels); each created node passes through GRAB, FREE when reused,
// MAKE and LINK, each freed node through UP and UNLINK, and every request through
// intake, start and result. The sequencer takes one request at a time; the node
// memory read port sets the one-level-per-cycle pace.
// Reset: synchronous; the root and the allocation pointers clear at once.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie #(
  parameter int NODE_COUNT = 4096,
  parameter int KEY_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  input  logic [31:0] in_prefix_mask,
  input  logic [31:0] in_insert_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [31:0] out_match_value
);
  import ipt_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // intake and queue
  ipt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_prefix_mask  (in_prefix_mask),
    .in_insert_value (in_insert_value),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // trie sequencer
  ipt_back #(
    .NODE_COUNT (NODE_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_match_value (out_match_value)
  );

endmodule

@@ tb/ipv4_prefix_trie_tb.sv @@
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_tb: self-checking bench for the prefix trie
// Drives insert, delete, find and unused-code requests through the valid and
// stall handshake. A shadow trie in the scoreboard predicts every response,
// including busy prefixes, node exhaustion and free-list reuse.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipt_pkg::*;

  localparam int NODES    = 4096;
  localparam int N_RANDOM = 680;
  localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] TOP_BIT  = 32'h8000_0000;
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value;
  } trie_resp_t;

  // shadow trie and queue of pending responses
  class trie_scoreboard;
    int unsigned lc[NODES];
    int unsigned rc[NODES];
    int unsigned par[NODES];
    logic [31:0] nval[NODES];
    bit          hv[NODES];
    int unsigned free_head;
    int unsigned next_unused;
    trie_resp_t  pending_q[$];
    int          errors;
    int          n_busy, n_nomem, n_hit;

    function new();
      lc[0] = 0;
      rc[0] = 0;
      hv[0] = 0;
      nval[0] = 0;
      free_head = NODES;
      next_unused = 1;
      errors = 0;
      n_busy = 0;
      n_nomem = 0;
      n_hit = 0;
    endfunction

    function int unsigned grab_node();
      int unsigned n;
      if (free_head < NODES) begin
        n = free_head;
        free_head = rc[n];
        if (free_head >= NODES || free_head == 0) free_head = NODES;
        return n;
      end
      if (next_unused < NODES) begin
        n = next_unused;
        next_unused++;
        return n;
      end
      return 0;
    endfunction

    function logic [1:0] insert_prefix(logic [31:0] key, logic [31:0] mask,
                                       logic [31:0] val);
      logic [31:0] bitm;
      int unsigned node, nxt;
      bit has;
      bitm = TOP_BIT;
      node = 0;
      has = (val != NO_VALUE);
      while ((bitm & mask) != 0) begin
        nxt = (key & bitm) ? rc[node] : lc[node];
        if (nxt == 0) break;
        bitm = bitm >> 1;
        node = nxt;
      end
      if ((bitm & mask) == 0) begin
        if (hv[node]) return STAT_BUSY;
        nval[node] = has ? val : 0;
        hv[node] = has;
        return STAT_OK;
      end
      while ((bitm & mask) != 0) begin
        nxt = grab_node();
        if (nxt == 0) return STAT_ERR;
        lc[nxt] = 0;
        rc[nxt] = 0;
        par[nxt] = node;
        nval[nxt] = 0;
        hv[nxt] = 0;
        if (key & bitm) rc[node] = nxt;
        else lc[node] = nxt;
        bitm = bitm >> 1;
        node = nxt;
      end
      nval[node] = has ? val : 0;
      hv[node] = has;
      return STAT_OK;
    endfunction

    function logic [1:0] delete_prefix(logic [31:0] key, logic [31:0] mask);
      logic [31:0] bitm;
      int unsigned node, up;
      bitm = TOP_BIT;
      node = 0;
      while ((bitm & mask) != 0) begin
        node = (key & bitm) ? rc[node] : lc[node];
        if (node == 0) return STAT_ERR;
        bitm = bitm >> 1;
      end
      if (rc[node] != 0 || lc[node] != 0) begin
        if (hv[node]) begin
          hv[node] = 0;
          nval[node] = 0;
          return STAT_OK;
        end
        return STAT_ERR;
      end
      if (node == 0) begin
        hv[0] = 0;
        nval[0] = 0;
        return STAT_OK;
      end
      // free childless nodes upward
      forever begin
        up = par[node];
        if (rc[up] == node) rc[up] = 0;
        else lc[up] = 0;
        rc[node] = (free_head < NODES) ? free_head : 0;
        free_head = node;
        node = up;
        if (rc[node] != 0 || lc[node] != 0) break;
        if (hv[node]) break;
        if (node == 0) break;
      end
      return STAT_OK;
    endfunction

    function trie_resp_t find_longest(logic [31:0] key);
      trie_resp_t r;
      logic [31:0] bitm;
      int unsigned node;
      int depth;
      r.found = 0;
      r.value = 0;
      bitm = TOP_BIT;
      node = 0;
      depth = 0;
      forever begin
        if (hv[node]) begin
          r.found = 1;
          r.value = nval[node];
        end
        if (depth >= 32) break;
        node = (key & bitm) ? rc[node] : lc[node];
        if (node == 0) break;
        bitm = bitm >> 1;
        depth++;
      end
      r.status = r.found ? STAT_OK : STAT_ERR;
      return r;
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] key,
                               logic [31:0] mask, logic [31:0] val);
      trie_resp_t r;
      r.status = STAT_ERR;
      r.found = 0;
      r.value = 0;
      case (op)
        OP_INSERT: begin
          r.status = insert_prefix(key, mask, val);
          if (r.status == STAT_BUSY) n_busy++;
          if (r.status == STAT_ERR) n_nomem++;
        end
        OP_DELETE: r.status = delete_prefix(key, mask);
        OP_FIND: begin
          r = find_longest(key);
          if (r.found) n_hit++;
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic found, logic [31:0] value);
      trie_resp_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: response with nothing pending: status %0d found %0d value %h",
                 $time, status, found, value);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (found !== e.found) begin
        $display("%0t: found expected %0d actual %0d", $time, e.found, found);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: match_value expected %h actual %h", $time, e.value, value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_prefix_mask = '0;
  logic [31:0] in_insert_value = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic        out_found;
  logic [31:0] out_match_value;

  trie_scoreboard sb = new();
  bit          quiet = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  int          hold_left = 0;
  logic [31:0] key_pool[10];
  logic [31:0] seen_keys[$];
  int          n_sent = 0;

  always #5 clk = ~clk;

  ipv4_prefix_trie u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_key(in_key),
    .in_prefix_mask(in_prefix_mask), .in_insert_value(in_insert_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found(out_found),
    .out_match_value(out_match_value)
  );

  // receiver back-pressure, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1;
    end else begin
      out_stall = quiet ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  // response checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_found, out_match_value);
  end

  function automatic logic [31:0] prefix_mask(int len, bit noise);
    logic [31:0] m;
    m = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    if (noise && len < 31) m = m | ($urandom & ((32'h1 << (31 - len)) - 1));
    return m;
  endfunction

  // offer one request and wait until it is taken
  task automatic send_request(logic [1:0] op, logic [31:0] key,
                              logic [31:0] mask, logic [31:0] val);
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_operation = op;
    in_key = key;
    in_prefix_mask = mask;
    in_insert_value = val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(op, key, mask, val);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic random_request(int idx);
    int          pick, len;
    logic [1:0]  op;
    logic [31:0] key, val;
    pick = $urandom_range(99);
    val = ($urandom_range(19) == 0) ? NO_VALUE : $urandom;
    if (seen_keys.size() > 0 && $urandom_range(1))
      key = seen_keys[$urandom_range(seen_keys.size() - 1)];
    else
      key = key_pool[$urandom_range(9)] ^ ($urandom >> $urandom_range(31));
    len = $urandom_range(32);
    if (idx >= 250 && idx < 400) begin
      // fill the node memory with long prefixes
      op = (pick < 85) ? OP_INSERT : OP_FIND;
      key = $urandom;
      len = $urandom_range(32, 24);
    end else if (idx >= 400 && idx < 500) begin
      op = (pick < 70) ? OP_DELETE : (pick < 85) ? OP_FIND : OP_INSERT;
    end else begin
      op = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_DELETE :
           (pick < 96) ? OP_FIND : OP_UNUSED;
    end
    if (op == OP_INSERT) begin
      seen_keys.push_back(key);
      if (seen_keys.size() > 200) void'(seen_keys.pop_front());
    end
    send_request(op, key, prefix_mask(len, $urandom_range(3) == 0), val);
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[8] = 32'h0;
    key_pool[9] = 32'hFFFF_FFFF;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed corners
    send_request(OP_DELETE, 32'h0, 32'h0, 32'h0);          // childless root
    send_request(OP_FIND, 32'h1234_5678, 32'h0, 32'h0);     // empty trie
    send_request(OP_INSERT, 32'h0, 32'h0, 32'h5);           // root prefix
    send_request(OP_INSERT, 32'h0, 32'h0, 32'h6);           // busy
    send_request(OP_FIND, 32'h0, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(OP_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'hC0A8_0000, 32'hFFFF_0000, NO_VALUE);
    send_request(OP_FIND, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hA);
    send_request(OP_INSERT, 32'hC0A8_0000, 32'hFFFF_0000, 32'hB); // valueless node
    send_request(OP_FIND, 32'hC0A8_01FF, 32'h0, 32'h0);
    send_request(OP_DELETE, 32'hC0A8_0000, 32'hFF00_0000, 32'h0); // inner, no value
    send_request(OP_DELETE, 32'h0A00_0000, 32'hFF00_0000, 32'h0); // missing path
    send_request(OP_DELETE, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0); // inner with value
    send_request(OP_DELETE, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0); // leaf
    send_request(OP_DELETE, 32'h0, 32'h0, 32'h0);          // root with children
    send_request(OP_FIND, 32'h0000_0001, 32'h0, 32'h0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000, 32'hBFFF_FFFF, 32'h7);
    send_request(OP_FIND, 32'h8000_0000, 32'h0, 32'h0);

    // random mix
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 100 && i < 180);
      if (i == 520) hold_req = 1;
      random_request(i);
    end
    in_valid = 0;
    quiet = 0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d requests: %0d busy inserts, %0d out-of-node inserts, %0d find hits",
             n_sent, sb.n_busy, sb.n_nomem, sb.n_hit);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("timeout with %0d responses pending", sb.pending_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ipt_pkg.sv
rtl/ipt_front.sv
rtl/ipt_back.sv
rtl/ipv4_prefix_trie.sv
tb/ipv4_prefix_trie_tb.sv
